@@ src/tpbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_pkg
// Shared widths, codes, register indexes and defaults of the touch detector.
// ----------------------------------------------------------------------------
package tpbd_pkg;

    localparam int ADC_W   = 12;
    localparam int PR_W    = 13;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;
    localparam int SX_W    = 9;
    localparam int SY_W    = 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 12;

    localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;

    localparam int DEF_PRESSURE_THRESHOLD = 400;
    localparam int DEF_SAMPLE_INTERVAL_MS = 50;
    localparam int DEF_SCREEN_COLUMNS     = 320;
    localparam int DEF_SCREEN_ROWS        = 240;

    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd0;
    localparam logic [STAT_W-1:0] ST_HELD     = 3'd1;
    localparam logic [STAT_W-1:0] ST_RATE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd4;
    localparam logic [STAT_W-1:0] ST_PRESSED  = 3'd5;

    localparam logic [CFG_AW-1:0] CFG_X_MIN  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_X_MAX  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_Y_MIN  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_Y_MAX  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LEFT   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TOP    = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_WIDTH  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_HEIGHT = 3'd7;

    localparam logic [ADC_W-1:0] RST_CAL_MIN = 12'd200;
    localparam logic [ADC_W-1:0] RST_CAL_MAX = 12'd3900;
    localparam logic [SX_W-1:0]  RST_LEFT    = 9'd0;
    localparam logic [SY_W-1:0]  RST_TOP     = 8'd0;
    localparam logic [SX_W-1:0]  RST_WIDTH   = 9'd320;
    localparam logic [SY_W-1:0]  RST_HEIGHT  = 8'd60;

endpackage

@@ src/tpbd_pair_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_pair_filter
// Averages the closest pair of three readings; ties favor ab, then ac.
// ----------------------------------------------------------------------------
module tpbd_pair_filter (
    input  logic [tpbd_pkg::ADC_W-1:0] i_a,
    input  logic [tpbd_pkg::ADC_W-1:0] i_b,
    input  logic [tpbd_pkg::ADC_W-1:0] i_c,
    output logic [tpbd_pkg::ADC_W-1:0] o_mean
);
    import tpbd_pkg::*;

    logic [ADC_W-1:0] w_ab;
    logic [ADC_W-1:0] w_ac;
    logic [ADC_W-1:0] w_bc;
    logic [ADC_W:0]   w_sum;

    assign w_ab = (i_a > i_b) ? i_a - i_b : i_b - i_a;
    assign w_ac = (i_a > i_c) ? i_a - i_c : i_c - i_a;
    assign w_bc = (i_b > i_c) ? i_b - i_c : i_c - i_b;

    always_comb begin
        if (w_ab <= w_ac && w_ab <= w_bc) begin
            w_sum = {1'b0, i_a} + {1'b0, i_b};
        end else if (w_ac <= w_bc) begin
            w_sum = {1'b0, i_a} + {1'b0, i_c};
        end else begin
            w_sum = {1'b0, i_b} + {1'b0, i_c};
        end
    end

    assign o_mean = w_sum[ADC_W:1];

endmodule

@@ src/tpbd_axis_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpbd_axis_map
// Maps a raw reading to a clamped pixel index: bit-serial shift-add multiply
// by (SPAN-1), then bit-serial restoring divide by the calibration run.
// ----------------------------------------------------------------------------
module tpbd_axis_map #(
    parameter int SPAN = tpbd_pkg::DEF_SCREEN_COLUMNS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpbd_pkg::ADC_W-1:0] i_raw,
    input  logic [tpbd_pkg::ADC_W-1:0] i_lo,
    input  logic [tpbd_pkg::ADC_W-1:0] i_hi,
    output logic                       o_done,
    output logic [tpbd_pkg::ADC_W-1:0] o_pix
);
    import tpbd_pkg::*;

    localparam int               PW      = 2 * ADC_W;
    localparam logic [ADC_W-1:0] SPAN_M1 = ADC_W'(SPAN - 1);
    localparam logic [4:0]       MUL_END = 5'(ADC_W - 1);
    localparam logic [4:0]       DIV_END = 5'(PW - 1);

    logic             r_busy;
    logic             r_div;
    logic [4:0]       r_cnt;
    logic [ADC_W-1:0] r_mcand;
    logic [ADC_W-1:0] r_mplier;
    logic [PW-1:0]    r_acc;
    logic [ADC_W-1:0] r_rem;
    logic [ADC_W-1:0] r_dvsr;
    logic             r_zero;
    logic             r_done;
    logic [ADC_W-1:0] r_pix;

    logic [ADC_W:0]   w_diff;
    logic [ADC_W:0]   w_run;
    logic [ADC_W:0]   w_diff_mag;
    logic [ADC_W:0]   w_run_mag;
    logic [ADC_W:0]   n_sum;
    logic [ADC_W+1:0] n_trial;
    logic [ADC_W:0]   n_shift;
    logic [PW-1:0]    n_quo;

    assign w_diff     = {1'b0, i_raw} - {1'b0, i_lo};
    assign w_run      = {1'b0, i_hi} - {1'b0, i_lo};
    assign w_diff_mag = w_diff[ADC_W] ? -w_diff : w_diff;
    assign w_run_mag  = w_run[ADC_W] ? -w_run : w_run;

    assign n_sum   = {1'b0, r_acc[PW-1:ADC_W]} + (r_mplier[0] ? {1'b0, r_mcand} : '0);
    assign n_shift = {r_rem, r_acc[PW-1]};
    assign n_trial = {1'b0, n_shift} - {2'b00, r_dvsr};
    assign n_quo   = {r_acc[PW-2:0], ~n_trial[ADC_W+1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_div  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!r_div) begin
                    if (r_cnt == MUL_END) begin
                        r_div <= 1'b1;
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end else begin
                    if (r_cnt == DIV_END) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= w_diff_mag[ADC_W-1:0];
            r_mplier <= SPAN_M1;
            r_acc    <= '0;
            r_rem    <= '0;
            r_dvsr   <= w_run_mag[ADC_W-1:0];
            r_zero   <= (w_run == '0) || (w_diff[ADC_W] ^ w_run[ADC_W]);
        end else if (r_busy && !r_div) begin
            r_acc    <= {n_sum, r_acc[ADC_W-1:1]};
            r_mplier <= r_mplier >> 1;
        end else if (r_busy) begin
            r_acc <= n_quo;
            if (n_trial[ADC_W+1]) begin
                r_rem <= n_shift[ADC_W-1:0];
            end else begin
                r_rem <= n_trial[ADC_W-1:0];
            end
            if (r_cnt == DIV_END) begin
                if (r_zero) begin
                    r_pix <= '0;
                end else if (n_quo > PW'(SPAN_M1)) begin
                    r_pix <= SPAN_M1;
                end else begin
                    r_pix <= n_quo[ADC_W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_pix  = r_pix;

endmodule

@@ src/touch_press_button_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_button_detector_unit
// Touch panel press detector: debounce, rate limit, filter, map, hit test.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) takes one panel snapshot per
// request; output channel (o_out_valid / i_out_stall) returns one status
// request with screen and raw coordinates and pressure.
// Config port: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high; write only while the block is idle.
// One snapshot is in flight at a time. Released, held, rate limited and
// rejected results go from the evaluate state to the done state; mapped
// results wait in the map state for the two bit-serial axis units (12
// multiply steps plus 24 divide steps, X and Y in parallel). The next
// snapshot is taken the cycle after the result enters the output register.
// A stalled result holds in the output register; the block waits in its
// final state until the register frees.
// Synchronous reset clears touch latch, sample time, handshake state and
// restores the calibration and button registers to their defaults.
// ----------------------------------------------------------------------------
module touch_press_button_detector_unit #(
    parameter int PRESSURE_THRESHOLD = tpbd_pkg::DEF_PRESSURE_THRESHOLD,
    parameter int SAMPLE_INTERVAL_MS = tpbd_pkg::DEF_SAMPLE_INTERVAL_MS,
    parameter int SCREEN_COLUMNS     = tpbd_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS        = tpbd_pkg::DEF_SCREEN_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tpbd_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [tpbd_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_irq_down,
    input  logic [tpbd_pkg::TIME_W-1:0] i_now_ms,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_z1_sample,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_z2_sample,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_x_sample_a,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_x_sample_b,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_x_sample_c,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_y_sample_a,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_y_sample_b,
    input  logic [tpbd_pkg::ADC_W-1:0]  i_y_sample_c,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tpbd_pkg::STAT_W-1:0] o_status,
    output logic [tpbd_pkg::SX_W-1:0]   o_screen_x,
    output logic [tpbd_pkg::SY_W-1:0]   o_screen_y,
    output logic [tpbd_pkg::ADC_W-1:0]  o_raw_x,
    output logic [tpbd_pkg::ADC_W-1:0]  o_raw_y,
    output logic [tpbd_pkg::PR_W-1:0]   o_pressure
);
    import tpbd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_MAP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [PR_W-1:0]   PR_THR   = PR_W'(PRESSURE_THRESHOLD);
    localparam logic [TIME_W-1:0] INTERVAL = TIME_W'(SAMPLE_INTERVAL_MS);

    logic [1:0]        r_state;
    logic              r_latched;
    logic [TIME_W-1:0] r_last;
    logic              r_out_valid;

    logic [ADC_W-1:0]  r_cal_x_min;
    logic [ADC_W-1:0]  r_cal_x_max;
    logic [ADC_W-1:0]  r_cal_y_min;
    logic [ADC_W-1:0]  r_cal_y_max;
    logic [SX_W-1:0]   r_btn_left;
    logic [SY_W-1:0]   r_btn_top;
    logic [SX_W-1:0]   r_btn_width;
    logic [SY_W-1:0]   r_btn_height;

    logic              r_irq;
    logic [TIME_W-1:0] r_now;
    logic [ADC_W-1:0]  r_z1;
    logic [ADC_W-1:0]  r_z2;
    logic [ADC_W-1:0]  r_xa;
    logic [ADC_W-1:0]  r_xb;
    logic [ADC_W-1:0]  r_xc;
    logic [ADC_W-1:0]  r_ya;
    logic [ADC_W-1:0]  r_yb;
    logic [ADC_W-1:0]  r_yc;

    logic [STAT_W-1:0] r_res_status;
    logic [SX_W-1:0]   r_res_sx;
    logic [SY_W-1:0]   r_res_sy;
    logic [ADC_W-1:0]  r_res_rx;
    logic [ADC_W-1:0]  r_res_ry;
    logic [PR_W-1:0]   r_res_pr;

    logic [STAT_W-1:0] r_out_status;
    logic [SX_W-1:0]   r_out_sx;
    logic [SY_W-1:0]   r_out_sy;
    logic [ADC_W-1:0]  r_out_rx;
    logic [ADC_W-1:0]  r_out_ry;
    logic [PR_W-1:0]   r_out_pr;

    logic              w_accept;
    logic [ADC_W-1:0]  w_fx;
    logic [ADC_W-1:0]  w_fy;
    logic [PR_W-1:0]   w_pr;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_rate_ok;
    logic              w_pr_ok;
    logic              w_axis_ok;
    logic              w_map_start;
    logic              w_x_done;
    logic              w_y_done;
    logic [ADC_W-1:0]  w_px;
    logic [ADC_W-1:0]  w_py;
    logic              w_inside;
    logic              w_load;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_pr      = {1'b0, r_z1} + {1'b0, ADC_FULL} - {1'b0, r_z2};
    assign w_elapsed = r_now - r_last;
    assign w_rate_ok = w_elapsed >= INTERVAL;
    assign w_pr_ok   = w_pr >= PR_THR;
    assign w_axis_ok = (w_fx != '0) && (w_fx != ADC_FULL) &&
                       (w_fy != '0) && (w_fy != ADC_FULL);
    assign w_map_start = (r_state == S_EVAL) && r_irq && !r_latched &&
                         w_rate_ok && w_pr_ok && w_axis_ok;
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_inside = ({1'b0, w_px} >= {4'b0, r_btn_left}) &&
                      ({1'b0, w_px} < ({4'b0, r_btn_left} + {4'b0, r_btn_width})) &&
                      ({1'b0, w_py} >= {5'b0, r_btn_top}) &&
                      ({1'b0, w_py} < ({5'b0, r_btn_top} + {5'b0, r_btn_height}));

    tpbd_pair_filter u_filt_x (
        .i_a    (r_xa),
        .i_b    (r_xb),
        .i_c    (r_xc),
        .o_mean (w_fx)
    );

    tpbd_pair_filter u_filt_y (
        .i_a    (r_ya),
        .i_b    (r_yb),
        .i_c    (r_yc),
        .o_mean (w_fy)
    );

    tpbd_axis_map #(
        .SPAN (SCREEN_COLUMNS)
    ) u_map_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_map_start),
        .i_raw   (w_fx),
        .i_lo    (r_cal_x_min),
        .i_hi    (r_cal_x_max),
        .o_done  (w_x_done),
        .o_pix   (w_px)
    );

    tpbd_axis_map #(
        .SPAN (SCREEN_ROWS)
    ) u_map_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_map_start),
        .i_raw   (w_fy),
        .i_lo    (r_cal_y_min),
        .i_hi    (r_cal_y_max),
        .o_done  (w_y_done),
        .o_pix   (w_py)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_x_min  <= RST_CAL_MIN;
            r_cal_x_max  <= RST_CAL_MAX;
            r_cal_y_min  <= RST_CAL_MIN;
            r_cal_y_max  <= RST_CAL_MAX;
            r_btn_left   <= RST_LEFT;
            r_btn_top    <= RST_TOP;
            r_btn_width  <= RST_WIDTH;
            r_btn_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_MIN:  r_cal_x_min  <= i_cfg_data;
                CFG_X_MAX:  r_cal_x_max  <= i_cfg_data;
                CFG_Y_MIN:  r_cal_y_min  <= i_cfg_data;
                CFG_Y_MAX:  r_cal_y_max  <= i_cfg_data;
                CFG_LEFT:   r_btn_left   <= i_cfg_data[SX_W-1:0];
                CFG_TOP:    r_btn_top    <= i_cfg_data[SY_W-1:0];
                CFG_WIDTH:  r_btn_width  <= i_cfg_data[SX_W-1:0];
                CFG_HEIGHT: r_btn_height <= i_cfg_data[SY_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_latched   <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_irq) begin
                        r_latched <= 1'b0;
                        r_state   <= S_DONE;
                    end else if (r_latched || !w_rate_ok) begin
                        r_state <= S_DONE;
                    end else begin
                        r_last <= r_now;
                        if (w_map_start) begin
                            r_latched <= 1'b1;
                            r_state   <= S_MAP;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MAP: begin
                    if (w_x_done && w_y_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_irq <= i_irq_down;
            r_now <= i_now_ms;
            r_z1  <= i_z1_sample;
            r_z2  <= i_z2_sample;
            r_xa  <= i_x_sample_a;
            r_xb  <= i_x_sample_b;
            r_xc  <= i_x_sample_c;
            r_ya  <= i_y_sample_a;
            r_yb  <= i_y_sample_b;
            r_yc  <= i_y_sample_c;
        end
        if (r_state == S_EVAL) begin
            r_res_sx <= '0;
            r_res_sy <= '0;
            r_res_rx <= '0;
            r_res_ry <= '0;
            r_res_pr <= '0;
            if (!r_irq) begin
                r_res_status <= ST_RELEASED;
            end else if (r_latched) begin
                r_res_status <= ST_HELD;
            end else if (!w_rate_ok) begin
                r_res_status <= ST_RATE;
            end else begin
                r_res_status <= ST_REJECTED;
                r_res_pr     <= w_pr;
                r_res_rx     <= w_fx;
                r_res_ry     <= w_fy;
            end
        end
        if (r_state == S_MAP && w_x_done && w_y_done) begin
            r_res_status <= w_inside ? ST_PRESSED : ST_OUTSIDE;
            r_res_sx     <= w_px[SX_W-1:0];
            r_res_sy     <= w_py[SY_W-1:0];
        end else if (r_state == S_DONE && r_res_status == ST_REJECTED) begin
            r_res_rx <= '0;
            r_res_ry <= '0;
        end
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_sx     <= r_res_sx;
            r_out_sy     <= r_res_sy;
            r_out_rx     <= (r_res_status == ST_REJECTED) ? '0 : r_res_rx;
            r_out_ry     <= (r_res_status == ST_REJECTED) ? '0 : r_res_ry;
            r_out_pr     <= r_res_pr;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_screen_x  = r_out_sx;
    assign o_screen_y  = r_out_sy;
    assign o_raw_x     = r_out_rx;
    assign o_raw_y     = r_out_ry;
    assign o_pressure  = r_out_pr;

endmodule
